// ===== hdl/ibus_pkg.sv =====
// Shared types and constants for the iBus frame receiver.
// No dependencies; imported by every module of the block.
package ibus_pkg;

   typedef logic [1:0] ibus_cmd_type;

   localparam ibus_cmd_type CMD_BYTE = 2'd0;
   localparam ibus_cmd_type CMD_TICK = 2'd1;
   localparam ibus_cmd_type CMD_READ = 2'd2;

   localparam int FRAME_SLOTS = 14;

   localparam logic [7:0]  HEADER_FIRST  = 8'h20;
   localparam logic [7:0]  HEADER_SECOND = 8'h40;
   localparam logic [15:0] NEUTRAL_VALUE = 16'd1500;
   localparam logic [15:0] SUM_BASE      = 16'hFFFF;
   localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

   localparam logic [4:0] POS_HUNT      = 5'd0;
   localparam logic [4:0] POS_HEADER2   = 5'd1;
   localparam logic [4:0] POS_DATA0     = 5'd2;
   localparam logic [4:0] POS_CHECK_LO  = 5'd30;
   localparam logic [4:0] POS_CHECK_HI  = 5'd31;

   typedef logic [FRAME_SLOTS-1:0][15:0] ibus_words_type;

   typedef struct packed {
      logic good;
      logic bad;
   } ibus_frame_status_type;

endpackage

// ===== hdl/ibus_frame_receiver.sv =====
// iBus frame receiver top level: input register, parser, store, result register.
// Beats pass the input, then the result register; one beat a cycle unless rsp_stall.
// Each beat updates state when it moves from the input register into the result register.
// Synchronous active-high reset: hunt for header, channels at 1500, elapsed 0, timeout 100.
// Depends on ibus_pkg, ibus_parser and ibus_chan_store.
module ibus_frame_receiver #(
   parameter int NUM_CHANNELS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ibus_pkg::ibus_cmd_type req_cmd,
   input  logic [7:0]            req_data_byte,
   input  logic [3:0]            req_channel_index,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_channel_value,
   output logic                  rsp_frame_good,
   output logic                  rsp_frame_bad,
   output logic                  rsp_receiving,
   // configuration
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data
);
   import ibus_pkg::*;

   // input register
   logic         in_valid_ff, in_valid_in;
   ibus_cmd_type in_cmd_ff;
   logic [7:0]   in_byte_ff;
   logic [3:0]   in_index_ff;

   // result register
   logic         out_valid_ff, out_valid_in;
   logic [15:0]  out_value_ff;
   logic         out_good_ff;
   logic         out_bad_ff;
   logic         out_recv_ff;

   logic [15:0]  timeout_ff;
   logic [15:0]  elapsed_ff, elapsed_in;

   logic                  req_take;
   logic                  advance;
   logic                  take_byte;
   ibus_frame_status_type frame_status;
   ibus_words_type        staged_words;
   logic [15:0]           store_value;
   logic [15:0]           value_in;

   // Advance the held beat whenever the result register is empty or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign take_byte = advance && (in_cmd_ff == CMD_BYTE);

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   ibus_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .take_en      (take_byte),
      .data_byte    (in_byte_ff),
      .status       (frame_status),
      .staged_words (staged_words)
   );

   ibus_chan_store #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .commit       (take_byte && frame_status.good),
      .staged_words (staged_words),
      .rd_index     (in_index_ff),
      .rd_value     (store_value)
   );

   // Elapsed counter: count up to saturation on a tick, clear on a good frame.
   always_comb begin
      elapsed_in = elapsed_ff;
      if (advance) begin
         if (in_cmd_ff == CMD_TICK) begin
            if (elapsed_ff != ELAPSED_MAX) begin
               elapsed_in = elapsed_ff + 16'd1;
            end
         end else if (take_byte && frame_status.good) begin
            elapsed_in = '0;
         end
      end
   end

   // Only a read beat carries a channel value; every other command reports zero.
   assign value_in = (in_cmd_ff == CMD_READ) ? store_value : 16'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= 16'd100;
         elapsed_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         elapsed_ff   <= elapsed_in;
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
      end
   end

   // Capture the request beat; payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= req_cmd;
         in_byte_ff  <= req_data_byte;
         in_index_ff <= req_channel_index;
      end
   end

   // Load the result register only on advance, so a stalled beat holds.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_value_ff <= value_in;
         out_good_ff  <= take_byte && frame_status.good;
         out_bad_ff   <= take_byte && frame_status.bad;
         out_recv_ff  <= (elapsed_in < timeout_ff);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_channel_value = out_value_ff;
   assign rsp_frame_good    = out_good_ff;
   assign rsp_frame_bad     = out_bad_ff;
   assign rsp_receiving     = out_recv_ff;

endmodule

// ===== hdl/ibus_parser.sv =====
// Frame parser: header hunt, running sum, checksum compare and staged words.
// Depends on ibus_pkg.
module ibus_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take_en,
   input  logic [7:0]                    data_byte,
   output ibus_pkg::ibus_frame_status_type status,
   output ibus_pkg::ibus_words_type      staged_words
);
   import ibus_pkg::*;

   logic [4:0]     pos_ff, pos_in;
   logic [15:0]    sum_ff, sum_in;
   logic [7:0]     check_lo_ff, check_lo_in;
   logic [7:0]     pend_ff, pend_in;
   ibus_words_type staged_ff;
   logic           stage_wr;
   logic [3:0]     stage_slot;
   logic [15:0]    expect_word;
   logic [15:0]    got_word;

   assign stage_slot  = pos_ff[4:1] - 4'd1;
   assign expect_word = SUM_BASE - sum_ff;
   assign got_word    = {data_byte, check_lo_ff};

   always_comb begin
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      check_lo_in = check_lo_ff;
      pend_in     = pend_ff;
      stage_wr    = 1'b0;
      status      = '0;
      if (take_en) begin
         if (pos_ff == POS_HUNT) begin
            if (data_byte == HEADER_FIRST) begin
               sum_in = {8'd0, data_byte};
               pos_in = POS_HEADER2;
            end
         end else if (pos_ff == POS_HEADER2) begin
            if (data_byte != HEADER_SECOND) begin
               pos_in = POS_HUNT;
            end else begin
               sum_in = sum_ff + {8'd0, data_byte};
               pos_in = POS_DATA0;
            end
         end else if (pos_ff < POS_CHECK_LO) begin
            sum_in = sum_ff + {8'd0, data_byte};
            if (!pos_ff[0]) begin
               pend_in = data_byte;
            end else begin
               stage_wr = 1'b1;
            end
            pos_in = pos_ff + 5'd1;
         end else if (pos_ff == POS_CHECK_LO) begin
            check_lo_in = data_byte;
            pos_in      = POS_CHECK_HI;
         end else begin
            status.good = (expect_word == got_word);
            status.bad  = (expect_word != got_word);
            pos_in      = POS_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_HUNT;
         sum_ff      <= '0;
         check_lo_ff <= '0;
         pend_ff     <= '0;
      end else begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         check_lo_ff <= check_lo_in;
         pend_ff     <= pend_in;
      end
   end

   // staged words carry no reset: every slot is written before a commit
   always_ff @(posedge clock) begin
      if (stage_wr) begin
         staged_ff[stage_slot] <= {data_byte, pend_ff};
      end
   end

   assign staged_words = staged_ff;

endmodule

// ===== hdl/ibus_chan_store.sv =====
// Committed channel store with neutral reset and bounded read.
// Depends on ibus_pkg.
module ibus_chan_store #(
   parameter int NUM_CHANNELS = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     commit,
   input  ibus_pkg::ibus_words_type staged_words,
   input  logic [3:0]               rd_index,
   output logic [15:0]              rd_value
);
   import ibus_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [NUM_CHANNELS-1:0][15:0] store_ff;
   logic [IDX_W-1:0]              rd_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            store_ff[i] <= NEUTRAL_VALUE;
         end
      end else if (commit) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            store_ff[i] <= staged_words[i];
         end
      end
   end

   assign rd_sel = rd_index[IDX_W-1:0];

   always_comb begin
      if (rd_index < 4'(NUM_CHANNELS)) begin
         rd_value = store_ff[rd_sel];
      end else begin
         rd_value = NEUTRAL_VALUE;
      end
   end

endmodule
